>>> src/assert_macros.svh
// Assertion macros shared by the keyboard event translator RTL.
// Used by the top level only; depends on signals clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define KET_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is followed by another one in the next cycle.
`define KET_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ket_pkg.sv
// Package of the keyboard event translator: field widths, key symbols and codes.
// Used by ket_keystate, ket_keymap and keyboard_event_translator.
package ket_pkg;

    localparam int SRC_W     = 2;
    localparam int KEYSYM_W  = 8;
    localparam int CODE_W    = 21;
    localparam int SIZE_W    = 9;
    localparam int LCOUNT_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam int DEF_NUM_SOURCES = 4;
    localparam int DEF_NUM_KEYS    = 256;
    localparam int DEF_NUM_LAYERS  = 2;

    localparam logic [LCOUNT_W-1:0] RST_LAYER_COUNT = 2'd2;
    localparam logic [SIZE_W-1:0]   RST_SIZE        = 9'd256;

    localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_SIZE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OTHER_LIMIT = 2'd3;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [KEYSYM_W-1:0] SYM_LSHIFT = 8'hE1;
    localparam logic [KEYSYM_W-1:0] SYM_RSHIFT = 8'hE5;
    localparam logic [KEYSYM_W-1:0] SYM_DELETE = 8'h4C;

    localparam int MOD_LCTRL = 0;
    localparam int MOD_LALT  = 1;
    localparam int MOD_RCTRL = 2;
    localparam int MOD_RALT  = 3;
    localparam int MOD_COUNT = 4;
    localparam logic [KEYSYM_W-1:0] MOD_SYM [MOD_COUNT] = '{8'hE0, 8'hE2, 8'hE4, 8'hE6};

    localparam logic [CODE_W-1:0] CHAR_TILDE = 21'h00007E;

    typedef enum logic [1:0] {
        ACT_PRESS   = 2'd0,
        ACT_REFIRE  = 2'd1,
        ACT_RELEASE = 2'd2
    } action_t;

    typedef struct packed {
        logic [LCOUNT_W-1:0] layer_count;
        logic [SIZE_W-1:0]   base_size;
        logic [SIZE_W-1:0]   shift_size;
        logic [SIZE_W-1:0]   other_limit;
    } cfg_t;

endpackage

>>> src/ket_keystate.sv
// Key-state memory: one bit per source for each keysym, with a clearing pass after
// reset and forwarding of a write-back to a read issued at the same edge. Uses ket_pkg.
module ket_keystate #(
    parameter int NUM_SOURCES = ket_pkg::DEF_NUM_SOURCES,
    parameter int NUM_KEYS    = ket_pkg::DEF_NUM_KEYS,
    parameter int KEY_AW      = $clog2(ket_pkg::DEF_NUM_KEYS)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rd_en,
    input  logic [KEY_AW-1:0]      rd_addr,
    output logic [NUM_SOURCES-1:0] rd_data,
    input  logic                   wr_en,
    input  logic [KEY_AW-1:0]      wr_addr,
    input  logic [NUM_SOURCES-1:0] wr_data,
    output logic                   busy
);
    import ket_pkg::*;

    logic [NUM_SOURCES-1:0] kb_mem [NUM_KEYS];
    logic                   clr_active_reg;
    logic                   clr_active_next;
    logic [KEY_AW-1:0]      clr_addr_reg;
    logic [KEY_AW-1:0]      clr_addr_next;
    logic [NUM_SOURCES-1:0] rd_q_reg;
    logic                   fwd_hit_reg;
    logic [NUM_SOURCES-1:0] fwd_data_reg;
    logic                   mem_we;
    logic [KEY_AW-1:0]      mem_waddr;
    logic [NUM_SOURCES-1:0] mem_wdata;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + KEY_AW'(1);
            if (clr_addr_reg == KEY_AW'(NUM_KEYS - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    assign mem_we    = clr_active_reg || wr_en;
    assign mem_waddr = clr_active_reg ? clr_addr_reg : wr_addr;
    assign mem_wdata = clr_active_reg ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            kb_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_q_reg     <= kb_mem[rd_addr];
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_q_reg;
    assign busy    = clr_active_reg;

endmodule

>>> src/ket_keymap.sv
// Keymap memory: one write port for load commands and two registered read ports,
// one for the shift layer and one for layer zero. Uses ket_pkg.
module ket_keymap #(
    parameter int NUM_LAYERS = ket_pkg::DEF_NUM_LAYERS,
    parameter int NUM_KEYS   = ket_pkg::DEF_NUM_KEYS,
    parameter int KM_AW      = $clog2(ket_pkg::DEF_NUM_LAYERS * ket_pkg::DEF_NUM_KEYS)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [KM_AW-1:0]          wr_addr,
    input  logic [ket_pkg::CODE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [KM_AW-1:0]          rd_addr0,
    input  logic [KM_AW-1:0]          rd_addr1,
    output logic [ket_pkg::CODE_W-1:0] rd_data0,
    output logic [ket_pkg::CODE_W-1:0] rd_data1
);
    import ket_pkg::*;

    localparam int KM_DEPTH = NUM_LAYERS * NUM_KEYS;

    logic [CODE_W-1:0] km_mem [KM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            km_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data0 <= km_mem[rd_addr0];
            rd_data1 <= km_mem[rd_addr1];
        end
    end

endmodule

>>> src/keyboard_event_translator.sv
// Top level of the keyboard event translator: handshakes, configuration registers,
// event classification and translation. Uses ket_pkg, ket_keystate and ket_keymap.
//
// Items enter on the s_ group. A key event (tuser = 0) comes out one result on the m_
// group; a keymap load (tuser = 1) writes one keymap entry and gives no result, as does
// an event whose source or keysym is out of range.
// An item accepted at one clock edge reads the key-state memory and both keymap
// layers at that edge; the classify stage then translates it, writes the new key
// state back and loads the output register once that register is free. One item is
// accepted every cycle while s_tready is high; a same-key write-back is forwarded to
// the read of the following item.
// The configuration channel is always ready and takes one register write per cycle.
// After reset the key-state memory is cleared one entry per cycle, and s_tready
// stays low meanwhile. Keymap entries are undefined until loaded.
// When the receiver stalls, the output register holds its item and one more item
// waits in the classify stage; s_tready then drops until the output is taken.
`include "assert_macros.svh"

module keyboard_event_translator #(
    parameter int NUM_SOURCES = ket_pkg::DEF_NUM_SOURCES,
    parameter int NUM_KEYS    = ket_pkg::DEF_NUM_KEYS,
    parameter int NUM_LAYERS  = ket_pkg::DEF_NUM_LAYERS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Bits from low: source(2), keysym(8), released(1), map_layer(1), map_code(21), zeros.
    input  logic [ket_pkg::IN_DATA_W-1:0]  s_tdata,
    // Bits from low: cmd(1).
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Bits from low: notify(1), action(2), raw_keysym(8), char_code(21), debug_char(1),
    // reboot(1), zeros.
    output logic [ket_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ket_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ket_pkg::SIZE_W-1:0]     cfg_data
);
    import ket_pkg::*;

    localparam int KEY_AW     = $clog2(NUM_KEYS);
    localparam int KM_AW      = $clog2(NUM_LAYERS * NUM_KEYS);
    localparam int KM_L1_BASE = (NUM_LAYERS > 1) ? NUM_KEYS : 0;
    localparam int SRC_CMP_W  = 5;
    localparam int SYM_CMP_W  = 11;

    cfg_t                   cfg_reg;
    logic [SRC_W-1:0]       in_source;
    logic [KEYSYM_W-1:0]    in_keysym;
    logic                   in_released;
    logic                   in_map_layer;
    logic [CODE_W-1:0]      in_map_code;
    logic                   in_is_load;
    logic                   src_ok;
    logic                   sym_ok;
    logic                   layer_ok;
    logic                   accept;
    logic                   load_we;
    logic                   ev_go;
    logic                   out_free;
    logic                   s1_fire;
    logic                   kb_busy;
    logic [NUM_SOURCES-1:0] kb_rd_data;
    logic [NUM_SOURCES-1:0] kb_new;
    logic [CODE_W-1:0]      km_rd_data0;
    logic [CODE_W-1:0]      km_rd_data1;
    logic [KM_AW-1:0]       km_waddr;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [SRC_W-1:0]       s1_src_reg;
    logic [KEYSYM_W-1:0]    s1_sym_reg;
    logic                   s1_pressed_reg;

    logic [1:0]             shift_reg [NUM_SOURCES];
    logic [1:0]             shift_next;
    logic [NUM_SOURCES-1:0] mod_reg [MOD_COUNT];
    logic [NUM_SOURCES-1:0] src_oh;
    logic [1:0]             shift_cur;
    logic [MOD_COUNT-1:0]   mod_held;
    logic                   oldstate;
    logic                   otherstate;
    logic                   notify;
    action_t                action;
    logic                   use_shift;
    logic                   prim_ok;
    logic                   base_ok;
    logic [CODE_W-1:0]      prim;
    logic [CODE_W-1:0]      trans;
    logic                   dbg;
    logic                   boot;

    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [OUT_DATA_W-1:0]  m_tdata_reg;
    logic [OUT_DATA_W-1:0]  m_tdata_next;

    assign in_source    = s_tdata[1:0];
    assign in_keysym    = s_tdata[9:2];
    assign in_released  = s_tdata[10];
    assign in_map_layer = s_tdata[11];
    assign in_map_code  = s_tdata[32:12];
    assign in_is_load   = (s_tuser[0] == CMD_LOAD);

    assign src_ok   = {3'b000, in_source} < SRC_CMP_W'(NUM_SOURCES);
    assign sym_ok   = {3'b000, in_keysym} < SYM_CMP_W'(NUM_KEYS);
    assign layer_ok = (NUM_LAYERS > 1) || !in_map_layer;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign s_tready = !kb_busy && (!s1_valid_reg || out_free);
    assign accept   = s_tvalid && s_tready;
    assign load_we  = accept && in_is_load && sym_ok && layer_ok;
    assign ev_go    = accept && !in_is_load && src_ok && sym_ok;
    assign km_waddr = in_map_layer ? (KM_AW'(KM_L1_BASE) + KM_AW'(in_keysym))
                                   : KM_AW'(in_keysym);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.layer_count <= RST_LAYER_COUNT;
            cfg_reg.base_size   <= RST_SIZE;
            cfg_reg.shift_size  <= RST_SIZE;
            cfg_reg.other_limit <= RST_SIZE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LAYER_COUNT: cfg_reg.layer_count <= cfg_data[LCOUNT_W-1:0];
                REG_BASE_SIZE:   cfg_reg.base_size   <= cfg_data;
                REG_SHIFT_SIZE:  cfg_reg.shift_size  <= cfg_data;
                REG_OTHER_LIMIT: cfg_reg.other_limit <= cfg_data;
                default:         cfg_reg.layer_count <= cfg_reg.layer_count;
            endcase
        end
    end

    ket_keystate #(
        .NUM_SOURCES (NUM_SOURCES),
        .NUM_KEYS    (NUM_KEYS),
        .KEY_AW      (KEY_AW)
    ) u_keystate (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ev_go),
        .rd_addr (KEY_AW'(in_keysym)),
        .rd_data (kb_rd_data),
        .wr_en   (s1_fire),
        .wr_addr (KEY_AW'(s1_sym_reg)),
        .wr_data (kb_new),
        .busy    (kb_busy)
    );

    ket_keymap #(
        .NUM_LAYERS (NUM_LAYERS),
        .NUM_KEYS   (NUM_KEYS),
        .KM_AW      (KM_AW)
    ) u_keymap (
        .clk      (clk),
        .wr_en    (load_we),
        .wr_addr  (km_waddr),
        .wr_data  (in_map_code),
        .rd_en    (ev_go),
        .rd_addr0 (KM_AW'(in_keysym)),
        .rd_addr1 (KM_AW'(KM_L1_BASE) + KM_AW'(in_keysym)),
        .rd_data0 (km_rd_data0),
        .rd_data1 (km_rd_data1)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (ev_go)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_go)
        begin
            s1_src_reg     <= in_source;
            s1_sym_reg     <= in_keysym;
            s1_pressed_reg <= !in_released;
        end
    end

    always_comb
    begin
        shift_cur = '0;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            src_oh[i] = (SRC_CMP_W'(i) == {3'b000, s1_src_reg});
            shift_cur = shift_cur | (shift_reg[i] & {2{src_oh[i]}});
        end
        for (int m = 0; m < MOD_COUNT; m++)
        begin
            mod_held[m] = (s1_sym_reg == MOD_SYM[m]) ? s1_pressed_reg : |(mod_reg[m] & src_oh);
        end

        oldstate   = |(kb_rd_data & src_oh);
        otherstate = ({1'b0, s1_sym_reg} < cfg_reg.other_limit) && |(kb_rd_data & ~src_oh);
        kb_new     = s1_pressed_reg ? (kb_rd_data | src_oh) : (kb_rd_data & ~src_oh);

        if (s1_pressed_reg)
        begin
            notify = 1'b1;
            action = (oldstate || otherstate) ? ACT_REFIRE : ACT_PRESS;
        end
        else
        begin
            notify = !otherstate;
            action = notify ? ACT_RELEASE : ACT_PRESS;
        end

        use_shift = |shift_cur;
        base_ok   = |cfg_reg.layer_count && ({1'b0, s1_sym_reg} < cfg_reg.base_size);
        prim_ok   = use_shift ? (cfg_reg.layer_count[1] && (NUM_LAYERS > 1)
                                 && ({1'b0, s1_sym_reg} < cfg_reg.shift_size))
                              : base_ok;
        prim      = prim_ok ? (use_shift ? km_rd_data1 : km_rd_data0) : '0;
        if (!s1_pressed_reg && notify)
        begin
            trans = '0;
        end
        else if (prim != '0)
        begin
            trans = prim;
        end
        else
        begin
            trans = base_ok ? km_rd_data0 : '0;
        end

        shift_next = shift_cur;
        if (s1_sym_reg == SYM_LSHIFT)
        begin
            shift_next = s1_pressed_reg ? (shift_cur | 2'b01) : (shift_cur & 2'b10);
        end
        else if (s1_sym_reg == SYM_RSHIFT)
        begin
            shift_next = s1_pressed_reg ? (shift_cur | 2'b10) : (shift_cur & 2'b01);
        end

        dbg  = 1'b0;
        boot = 1'b0;
        if (s1_pressed_reg && mod_held[MOD_LCTRL] && mod_held[MOD_LALT])
        begin
            dbg = (trans != CHAR_TILDE);
        end
        else if (s1_pressed_reg && (mod_held[MOD_LCTRL] || mod_held[MOD_RCTRL])
                 && (mod_held[MOD_LALT] || mod_held[MOD_RALT])
                 && (s1_sym_reg == SYM_DELETE))
        begin
            boot = 1'b1;
        end

        m_tdata_next = {6'b000000, boot, dbg, notify ? trans : CODE_W'(0), s1_sym_reg,
                        notify ? action : ACT_PRESS, notify};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                shift_reg[i] <= '0;
            end
            for (int m = 0; m < MOD_COUNT; m++)
            begin
                mod_reg[m] <= '0;
            end
        end
        else if (s1_fire)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                if (src_oh[i])
                begin
                    shift_reg[i] <= shift_next;
                end
            end
            for (int m = 0; m < MOD_COUNT; m++)
            begin
                if (s1_sym_reg == MOD_SYM[m])
                begin
                    mod_reg[m] <= s1_pressed_reg ? (mod_reg[m] | src_oh)
                                                 : (mod_reg[m] & ~src_oh);
                end
            end
        end
    end

    assign m_tvalid_next = s1_fire || (m_tvalid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `KET_ASSERT(a_out_from_stage, $rose(m_tvalid_reg) |-> $past(s1_valid_reg), "result without a classified item")
    `KET_ASSERT_NEXT(a_stage_moves, s1_valid_reg && !m_tvalid_reg, m_tvalid_reg, "classified item not moved to output")
    `KET_ASSERT_NEXT(a_stage_holds, s1_valid_reg && m_tvalid_reg && !m_tready, s1_valid_reg && $stable(s1_sym_reg), "stalled item lost")
    `KET_ASSERT(a_no_work_in_clear, kb_busy |-> !s1_valid_reg && !m_tvalid_reg, "item in flight during clearing pass")

endmodule

>>> verif/ket_result_check.sv
// Result checker for the keyboard event translator: tracks key state, shift state and keymap
// from accepted items, registers from writes, and compares every result with its prediction.
// Depends on ket_pkg for field widths, key symbols, register indexes and the action codes.
`timescale 1ns / 100ps

module ket_result_check
    import ket_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SIZE_W-1:0]     cfg_data,
    output int                    errors,
    output int                    outstanding,
    output int                    n_checked,
    output int                    n_refire,
    output int                    n_silent,
    output int                    n_debug,
    output int                    n_reboot
);

    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic                boot;
        logic                dbg;
        logic [CODE_W-1:0]   code;
        logic [KEYSYM_W-1:0] sym;
        action_t             act;
        logic                notify;
    } key_result_t;

    cfg_t                        cfg;
    logic [DEF_NUM_SOURCES-1:0]  held_by [DEF_NUM_KEYS];
    logic [1:0]                  shift_by [DEF_NUM_SOURCES];
    logic [CODE_W-1:0]           keymap [DEF_NUM_LAYERS][DEF_NUM_KEYS];
    key_result_t                 pending_results [$];

    function automatic logic [CODE_W-1:0] map_read(logic layer, logic [KEYSYM_W-1:0] sym);
        logic [SIZE_W-1:0] size;
        size = layer ? cfg.shift_size : cfg.base_size;
        if (layer >= cfg.layer_count || {1'b0, sym} >= size)
            return '0;
        return keymap[layer][sym];
    endfunction

    function automatic string show_result(key_result_t r);
        return $sformatf("keysym %02h notify %0d action %0d char %06h debug %0d reboot %0d",
                         r.sym, r.notify, r.act, r.code, r.dbg, r.boot);
    endfunction

    function automatic key_result_t translate_key(logic [SRC_W-1:0] src,
                                                  logic [KEYSYM_W-1:0] sym, logic rel);
        key_result_t                r;
        logic [DEF_NUM_SOURCES-1:0] mask;
        logic [DEF_NUM_SOURCES-1:0] others;
        logic                       was_held;
        logic                       other_held;
        logic                       press;
        logic                       lctrl;
        logic                       lalt;
        logic                       rctrl;
        logic                       ralt;
        logic [CODE_W-1:0]          code;
        action_t                    act;

        press      = !rel;
        mask       = DEF_NUM_SOURCES'(1) << src;
        was_held   = held_by[sym][src];
        others     = held_by[sym] & ~mask;
        other_held = ({1'b0, sym} < cfg.other_limit) && (others != 0);
        held_by[sym] = press ? (held_by[sym] | mask) : (held_by[sym] & ~mask);

        if (press)
            act = (was_held || other_held) ? ACT_REFIRE : ACT_PRESS;
        else
            act = other_held ? ACT_PRESS : ACT_RELEASE;
        r.notify = press || !other_held;

        code = '0;
        if (!(r.notify && act == ACT_RELEASE))
        begin
            code = map_read(shift_by[src] != 0, sym);
            if (code == 0 && cfg.layer_count >= 1 && {1'b0, sym} < cfg.base_size)
                code = keymap[0][sym];
        end

        if (sym == SYM_LSHIFT)
            shift_by[src][0] = press;
        else if (sym == SYM_RSHIFT)
            shift_by[src][1] = press;

        lctrl = held_by[MOD_SYM[MOD_LCTRL]][src];
        lalt  = held_by[MOD_SYM[MOD_LALT]][src];
        rctrl = held_by[MOD_SYM[MOD_RCTRL]][src];
        ralt  = held_by[MOD_SYM[MOD_RALT]][src];

        r.act  = r.notify ? act : ACT_PRESS;
        r.sym  = sym;
        r.code = r.notify ? code : '0;
        r.dbg  = 1'b0;
        r.boot = 1'b0;
        if (press && lctrl && lalt)
            r.dbg = (code != CHAR_TILDE);
        else if (press && (lctrl || rctrl) && (lalt || ralt) && sym == SYM_DELETE)
            r.boot = 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        key_result_t want;
        key_result_t got;
        if (!rst_n)
        begin
            cfg.layer_count = RST_LAYER_COUNT;
            cfg.base_size   = RST_SIZE;
            cfg.shift_size  = RST_SIZE;
            cfg.other_limit = RST_SIZE;
            for (int k = 0; k < DEF_NUM_KEYS; k++)
                held_by[k] = '0;
            for (int s = 0; s < DEF_NUM_SOURCES; s++)
                shift_by[s] = '0;
            pending_results.delete();
            errors      = 0;
            n_checked   = 0;
            n_refire    = 0;
            n_silent    = 0;
            n_debug     = 0;
            n_reboot    = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LAYER_COUNT: cfg.layer_count = cfg_data[LCOUNT_W-1:0];
                    REG_BASE_SIZE:   cfg.base_size   = cfg_data;
                    REG_SHIFT_SIZE:  cfg.shift_size  = cfg_data;
                    REG_OTHER_LIMIT: cfg.other_limit = cfg_data;
                    default:         ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                got = key_result_t'(m_tdata[$bits(key_result_t)-1:0]);
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("Unexpected result for keysym %02h at %0t", got.sym, $time);
                end
                else
                begin
                    want = pending_results.pop_front();
                    n_checked++;
                    if (got.notify !== want.notify || got.act !== want.act
                        || got.sym !== want.sym || got.code !== want.code
                        || got.dbg !== want.dbg || got.boot !== want.boot)
                    begin
                        errors++;
                        if (errors <= MAX_SHOWN)
                        begin
                            $display("Mismatch at %0t, expected: %s", $time, show_result(want));
                            $display("    actual: %s", show_result(got));
                        end
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == CMD_LOAD)
                    keymap[s_tdata[11]][s_tdata[9:2]] = s_tdata[32:12];
                else
                begin
                    want = translate_key(s_tdata[1:0], s_tdata[9:2], s_tdata[10]);
                    if (want.act == ACT_REFIRE)
                        n_refire++;
                    if (!want.notify)
                        n_silent++;
                    if (want.dbg)
                        n_debug++;
                    if (want.boot)
                        n_reboot++;
                    pending_results.push_back(want);
                end
            end

            outstanding <= pending_results.size();
        end
    end

endmodule

>>> verif/tb.sv
// Top of the keyboard event translator testbench: clock, reset, item and register traffic,
// receiver stalls and the final verdict. Depends on ket_pkg, the translator RTL and
// ket_result_check, which predicts and compares the results.
`timescale 1ns / 100ps

module tb;
    import ket_pkg::*;

    localparam int LIMIT       = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 8;
    localparam int PHASE_ITEMS = 130;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [SIZE_W-1:0]     cfg_data  = '0;

    int errors;
    int outstanding;
    int n_checked;
    int n_refire;
    int n_silent;
    int n_debug;
    int n_reboot;

    int cycle_count   = 0;
    int burst_left    = 0;
    int events_sent   = 0;
    int settings_used = 1;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;

    keyboard_event_translator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ket_result_check result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding),
        .n_checked   (n_checked),
        .n_refire    (n_refire),
        .n_silent    (n_silent),
        .n_debug     (n_debug),
        .n_reboot    (n_reboot)
    );

    always #2 clk = ~clk;

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // The receiver changes its stall pattern every segment and holds off once for a long
    // stretch so that the translator fills up and stops taking items.
    initial
    begin
        int mode;
        int seg;
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(10, 150);
            for (int i = 0; i < seg && !(hold_req && !hold_done); i++)
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= (i % 5 < 2);
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic send_item(logic cmd, logic [IN_DATA_W-1:0] data);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic key_event(logic [SRC_W-1:0] src, logic [KEYSYM_W-1:0] sym, logic rel);
        events_sent++;
        send_item(CMD_KEY, {7'b0, 21'($urandom), 1'($urandom), rel, sym, src});
    endtask

    task automatic load_entry(logic layer, logic [KEYSYM_W-1:0] idx, logic [CODE_W-1:0] code);
        send_item(CMD_LOAD, {7'b0, code, layer, 1'($urandom), idx, 2'($urandom)});
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic apply_settings(logic [LCOUNT_W-1:0] lc, logic [SIZE_W-1:0] base,
                                  logic [SIZE_W-1:0] shift, logic [SIZE_W-1:0] limit);
        put_reg(REG_LAYER_COUNT, SIZE_W'(lc));
        put_reg(REG_BASE_SIZE, base);
        put_reg(REG_SHIFT_SIZE, shift);
        put_reg(REG_OTHER_LIMIT, limit);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic logic [CODE_W-1:0] random_code();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CHAR_TILDE;
            2:       return '1;
            default: return CODE_W'($urandom);
        endcase
    endfunction

    function automatic logic [KEYSYM_W-1:0] pick_sym();
        case ($urandom_range(0, 15))
            0, 1, 2, 3: return KEYSYM_W'($urandom);
            4:          return MOD_SYM[MOD_LCTRL];
            5:          return MOD_SYM[MOD_LALT];
            6:          return MOD_SYM[MOD_RCTRL];
            7:          return MOD_SYM[MOD_RALT];
            8:          return SYM_LSHIFT;
            9:          return SYM_RSHIFT;
            10:         return SYM_DELETE;
            11:         return 8'h00;
            12:         return 8'hFF;
            default:    return KEYSYM_W'($urandom_range(0, 7));
        endcase
    endfunction

    // Modifier chord on one keyboard: ctrl, alt, optional shift, then the key.
    // Some of the closing releases are dropped to leave keys stuck.
    task automatic chord();
        logic [SRC_W-1:0]    src;
        logic [KEYSYM_W-1:0] ctrl;
        logic [KEYSYM_W-1:0] alt;
        logic [KEYSYM_W-1:0] shift;
        logic [KEYSYM_W-1:0] key;
        logic                shifted;
        src     = SRC_W'($urandom);
        ctrl    = $urandom_range(0, 1) ? MOD_SYM[MOD_LCTRL] : MOD_SYM[MOD_RCTRL];
        alt     = $urandom_range(0, 1) ? MOD_SYM[MOD_LALT] : MOD_SYM[MOD_RALT];
        shift   = $urandom_range(0, 1) ? SYM_LSHIFT : SYM_RSHIFT;
        key     = $urandom_range(0, 1) ? SYM_DELETE : pick_sym();
        shifted = ($urandom_range(0, 3) == 0);
        key_event(src, ctrl, 1'b0);
        key_event(src, alt, 1'b0);
        if (shifted)
            key_event(src, shift, 1'b0);
        repeat ($urandom_range(1, 3)) key_event(src, key, 1'b0);
        if ($urandom_range(0, 7) != 0)
            key_event(src, key, 1'b1);
        if (shifted)
            key_event(src, shift, 1'b1);
        if ($urandom_range(0, 7) != 0)
            key_event(src, alt, 1'b1);
        if ($urandom_range(0, 7) != 0)
            key_event(src, ctrl, 1'b1);
    endtask

    task automatic random_phase(int count);
        int target;
        target = events_sent + count;
        while (events_sent < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: chord();
                4:          load_entry(1'($urandom), KEYSYM_W'($urandom), random_code());
                default:    key_event(SRC_W'($urandom), pick_sym(), 1'($urandom));
            endcase
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Every keymap entry is loaded before any key event can read it.
        for (int layer = 0; layer < DEF_NUM_LAYERS; layer++)
            for (int idx = 0; idx < DEF_NUM_KEYS; idx++)
                load_entry(1'(layer), KEYSYM_W'(idx), random_code());

        load_entry(1'b0, 8'h04, CHAR_TILDE);
        load_entry(1'b0, 8'h05, '1);
        load_entry(1'b1, 8'h05, '0);
        key_event(2'd0, 8'h00, 1'b0);
        key_event(2'd3, 8'hFF, 1'b0);
        key_event(2'd0, 8'h00, 1'b0);
        key_event(2'd1, 8'h00, 1'b0);
        key_event(2'd0, 8'h00, 1'b1);
        key_event(2'd1, 8'h00, 1'b1);
        key_event(2'd2, 8'h80, 1'b1);
        key_event(2'd2, SYM_RSHIFT, 1'b0);
        key_event(2'd2, 8'h05, 1'b0);
        key_event(2'd2, 8'h05, 1'b1);
        key_event(2'd2, SYM_RSHIFT, 1'b1);
        key_event(2'd0, MOD_SYM[MOD_LCTRL], 1'b0);
        key_event(2'd0, MOD_SYM[MOD_LALT], 1'b0);
        key_event(2'd0, 8'h04, 1'b0);
        key_event(2'd0, 8'h10, 1'b0);
        key_event(2'd0, SYM_DELETE, 1'b0);
        key_event(2'd0, MOD_SYM[MOD_LALT], 1'b1);
        key_event(2'd0, MOD_SYM[MOD_RALT], 1'b0);
        key_event(2'd0, SYM_DELETE, 1'b0);
        key_event(2'd0, MOD_SYM[MOD_RALT], 1'b1);
        key_event(2'd0, MOD_SYM[MOD_LCTRL], 1'b1);
        key_event(2'd3, 8'hFF, 1'b1);
        settle();

        apply_settings(2'd0, 9'd0, 9'd0, 9'd0);
        random_phase(PHASE_ITEMS);
        settle();
        apply_settings(2'd1, 9'($urandom_range(0, 256)), 9'($urandom_range(0, 256)),
                       9'($urandom_range(0, 256)));
        hold_req = 1'b1;
        random_phase(PHASE_ITEMS);
        settle();
        apply_settings(2'd2, 9'd256, 9'd0, 9'd256);
        random_phase(PHASE_ITEMS);
        settle();
        apply_settings(2'd2, 9'($urandom_range(0, 256)), 9'($urandom_range(0, 256)),
                       9'($urandom_range(0, 256)));
        random_phase(PHASE_ITEMS);
        settle();
        apply_settings(2'd1, 9'd256, 9'd256, 9'd0);
        random_phase(PHASE_ITEMS);
        settle();
        apply_settings(2'd2, 9'd256, 9'd256, 9'd256);
        random_phase(PHASE_ITEMS);
        settle();

        $display("Checked %0d key events over %0d register settings, %0d of them refires.",
                 n_checked, settings_used, n_refire);
        $display("Saw %0d suppressed releases, %0d debug chords and %0d reboot requests.",
                 n_silent, n_debug, n_reboot);
        if (errors == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> keyboard_event_translator.f
+incdir+src
src/ket_pkg.sv
src/ket_keystate.sv
src/ket_keymap.sv
src/keyboard_event_translator.sv
verif/ket_result_check.sv
verif/tb.sv
